### design/scp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the segment screen clip unit.
// Depends on nothing; every other file of the unit but scp_div imports it.
package scp_pkg;

  localparam int unsigned XW  = 12;  // pixel column or row of a result
  localparam int unsigned CW  = 24;  // integer part of a Q24.8 coordinate
  localparam int unsigned DXW = 24;  // |dx| and |dy|
  localparam int unsigned DYW = 25;  // signed dy and raw differences
  localparam int unsigned PRW = 50;  // products, intercept sums and numerators
  localparam int unsigned MW  = 49;  // floored Q-scaled intercept numerator
  localparam int unsigned DVW = 48;  // dividend width of the intercept dividers
  localparam int unsigned LW  = 37;  // H*|dx|, W*|dy| and the crossing dividend

  localparam int unsigned DEF_W = 1024;
  localparam int unsigned DEF_H = 1024;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } scp_in_t;

  typedef struct packed {
    logic                 visible;
    logic [XW-1:0]        clip_x;
    logic [XW-1:0]        clip_y;
    logic signed [CW-1:0] depth_max;
  } scp_out_t;

  // Travels beside the intercept dividers.
  typedef struct packed {
    logic                  vis;
    logic signed [CW-1:0]  zmax;
    logic                  early;
    logic [XW-1:0]         ecx;
    logic [XW-1:0]         ecy;
    logic                  fx_ge_w;
    logic                  fx_lt0;
    logic                  fy_ge_h;
    logic                  fy_lt0;
    logic                  mneg;
    logic signed [MW-1:0]  m;
    logic [DXW-1:0]        dx;
    logic                  dyneg;
    logic [DXW-1:0]        ady;
    logic [LW-1:0]         hdx;
    logic [LW-1:0]         wady;
  } scp_side_t;

  // Travels beside the crossing-column divider.
  typedef struct packed {
    logic                 vis;
    logic signed [CW-1:0] zmax;
    logic                 usediv;
    logic                 lo;
    logic                 hi;
    logic [XW-1:0]        fcx;
    logic [XW-1:0]        fcy;
  } scp_tail_t;

  // Clamp a signed pixel coordinate into 0 .. lim-1.
  function automatic logic [XW-1:0] sat_pix(logic signed [CW-1:0] v,
                                            logic signed [CW-1:0] lim);
    logic signed [CW-1:0] top;
    logic [XW-1:0]        res;
    top = CW'(lim - 1);
    if (v < 0) begin
      res = '0;
    end else if (v > top) begin
      res = top[XW-1:0];
    end else begin
      res = v[XW-1:0];
    end
    return res;
  endfunction

endpackage

### design/scp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Uses no package items.
module scp_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 24,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] side_o
);

  logic [NW-1:0] vld_q;
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [PW-1:0] side_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NW-1:0] n_in;
    logic [PW-1:0] s_in;
    logic [DW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign n_in = num_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = vld_q[i-1];
      assign r_in = rem_q[i-1];
      assign d_in = den_q[i-1];
      assign n_in = num_q[i-1];
      assign s_in = side_q[i-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
      num_q[i]  <= {n_in[NW-2:0], take};
      den_q[i]  <= d_in;
      side_q[i] <= s_in;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = num_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

### design/scp_front.sv
`timescale 1ns / 1ps
// Front four stages: floors, differences, products, visibility and early clips.
// Depends on scp_pkg.
module scp_front #(
  parameter int unsigned SCREEN_WIDTH  = scp_pkg::DEF_W,
  parameter int unsigned SCREEN_HEIGHT = scp_pkg::DEF_H
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  scp_pkg::scp_in_t            item_i,
  output logic                        valid_o,
  output scp_pkg::scp_side_t          side_o,
  output logic [scp_pkg::DVW-1:0]     diva_o,
  output logic [scp_pkg::DVW-1:0]     divb_o,
  output logic                        pneg_o
);
  import scp_pkg::*;

  localparam logic signed [CW-1:0]  WC   = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0]  HC   = CW'(SCREEN_HEIGHT);
  localparam logic signed [PRW-1:0] WM1  = PRW'(SCREEN_WIDTH - 1);
  localparam logic signed [PRW-1:0] WS   = PRW'(SCREEN_WIDTH);
  localparam logic [LW-1:0]         WL   = LW'(SCREEN_WIDTH);
  localparam logic [LW-1:0]         HL   = LW'(SCREEN_HEIGHT);
  localparam logic [XW-1:0]         WTOP = XW'(SCREEN_WIDTH - 1);
  localparam logic [XW-1:0]         HTOP = XW'(SCREEN_HEIGHT - 1);

  typedef struct packed {
    logic signed [31:0]    sx;
    logic signed [31:0]    sy;
    logic signed [CW-1:0]  fx0;
    logic signed [CW-1:0]  fy0;
    logic signed [CW-1:0]  fx1;
    logic signed [CW-1:0]  fy1;
    logic [DXW-1:0]        dx;
    logic signed [DYW-1:0] dy;
    logic signed [CW-1:0]  zm;
  } st1_t;

  typedef struct packed {
    logic                 in01;
    logic                 rej;
    logic                 dx0;
    logic                 dy0;
    logic                 vvis;
    logic                 hvis;
    logic                 dyneg;
    logic                 early;
    logic [XW-1:0]        ecx;
    logic [XW-1:0]        ecy;
    logic                 fx_ge_w;
    logic                 fx_lt0;
    logic                 fy_ge_h;
    logic                 fy_lt0;
    logic signed [CW-1:0] zm;
    logic [DXW-1:0]       dx;
    logic [DXW-1:0]       ady;
    logic [LW-1:0]        hdx;
    logic [LW-1:0]        wady;
  } flg_t;

  // Stage 1: integer parts, direction-normalized differences, depth.
  logic signed [CW-1:0]  fx0_c, fy0_c, fx1_c, fy1_c;
  logic signed [DYW-1:0] dxr_c, dyr_c;
  logic signed [31:0]    zmax_c, zadj_c;
  st1_t                  st1_d, st1_q;
  logic                  v1_q;

  assign fx0_c  = item_i.start_x[31:8];
  assign fy0_c  = item_i.start_y[31:8];
  assign fx1_c  = item_i.end_x[31:8];
  assign fy1_c  = item_i.end_y[31:8];
  assign dxr_c  = DYW'(fx1_c) - DYW'(fx0_c);
  assign dyr_c  = DYW'(fy1_c) - DYW'(fy0_c);
  assign zmax_c = (item_i.start_z >= item_i.end_z) ? item_i.start_z : item_i.end_z;
  // Division by 256 that truncates toward zero.
  assign zadj_c = zmax_c + {24'b0, {8{zmax_c[31]}}};

  always_comb begin
    st1_d.sx  = item_i.start_x;
    st1_d.sy  = item_i.start_y;
    st1_d.fx0 = fx0_c;
    st1_d.fy0 = fy0_c;
    st1_d.fx1 = fx1_c;
    st1_d.fy1 = fy1_c;
    st1_d.dx  = dxr_c[DYW-1] ? DXW'(-dxr_c) : DXW'(dxr_c);
    st1_d.dy  = dxr_c[DYW-1] ? -dyr_c : dyr_c;
    st1_d.zm  = zadj_c[31:8];
  end

  // Stage 2: all products and the screen-edge flags.
  logic signed [56:0]    p1_c, p2_c;
  logic signed [PRW-1:0] p3_c, p4_c, p5_c, pp_c;
  logic                  x0lt, x0ge, y0lt, y0ge, x1lt, x1ge, y1lt, y1ge, in0;
  flg_t                  fl2_d, fl2_q;
  logic signed [56:0]    p1_q, p2_q;
  logic signed [PRW-1:0] p3_q, p4_q, p5_q, pp2_q;
  logic                  v2_q;

  assign p1_c = st1_q.sy * $signed({1'b0, st1_q.dx});
  assign p2_c = st1_q.dy * st1_q.sx;
  assign p3_c = st1_q.fy0 * $signed({1'b0, st1_q.dx});
  assign p4_c = st1_q.dy * st1_q.fx0;
  assign p5_c = st1_q.dy * WM1;
  assign pp_c = st1_q.dy * WS;

  assign x0lt = st1_q.fx0 < 0;
  assign x0ge = st1_q.fx0 >= WC;
  assign y0lt = st1_q.fy0 < 0;
  assign y0ge = st1_q.fy0 >= HC;
  assign x1lt = st1_q.fx1 < 0;
  assign x1ge = st1_q.fx1 >= WC;
  assign y1lt = st1_q.fy1 < 0;
  assign y1ge = st1_q.fy1 >= HC;
  assign in0  = !x0lt && !x0ge && !y0lt && !y0ge;

  always_comb begin
    fl2_d.in01    = in0 || (!x1lt && !x1ge && !y1lt && !y1ge);
    fl2_d.rej     = (x0lt && x1lt) || (x0ge && x1ge) || (y0lt && y1lt) || (y0ge && y1ge);
    fl2_d.dx0     = st1_q.dx == '0;
    fl2_d.dy0     = st1_q.dy == '0;
    fl2_d.vvis    = !x0lt && !x0ge;
    fl2_d.hvis    = !y0lt && !y0ge;
    fl2_d.dyneg   = st1_q.dy[DYW-1];
    fl2_d.early   = in0 || fl2_d.dx0 || fl2_d.dy0;
    fl2_d.fx_ge_w = x0ge;
    fl2_d.fx_lt0  = x0lt;
    fl2_d.fy_ge_h = y0ge;
    fl2_d.fy_lt0  = y0lt;
    fl2_d.zm      = st1_q.zm;
    fl2_d.dx      = st1_q.dx;
    fl2_d.ady     = st1_q.dy[DYW-1] ? DXW'(-st1_q.dy) : DXW'(st1_q.dy);
    fl2_d.hdx     = HL * LW'(st1_q.dx);
    fl2_d.wady    = WL * LW'(fl2_d.ady);
    // Clip of the first endpoint when it is on screen or the segment is
    // axis aligned.
    if (in0) begin
      fl2_d.ecx = st1_q.fx0[XW-1:0];
      fl2_d.ecy = st1_q.fy0[XW-1:0];
    end else if (fl2_d.dx0) begin
      fl2_d.ecx = sat_pix(st1_q.fx0, WC);
      fl2_d.ecy = y0ge ? HTOP : '0;
    end else begin
      fl2_d.ecx = x0ge ? WTOP : '0;
      fl2_d.ecy = sat_pix(st1_q.fy0, HC);
    end
  end

  // Stage 3: intercept numerators.
  logic signed [56:0]    diff_c;
  logic signed [MW-1:0]  m_q;
  logic signed [PRW-1:0] n_q, w_q, pp3_q;
  flg_t                  fl3_q;
  logic                  v3_q;

  assign diff_c = p1_q - p2_q;

  // Stage 4: visibility decision and divider operands.
  logic     vis_c, mneg_c, pneg_c;
  logic signed [PRW-1:0] hdxs_c;
  scp_side_t side_d;

  assign hdxs_c = $signed(PRW'(fl3_q.hdx));
  assign mneg_c = m_q[MW-1];
  assign pneg_c = pp3_q[PRW-1];

  always_comb begin
    priority if (fl3_q.in01) begin
      vis_c = 1'b1;
    end else if (fl3_q.rej) begin
      vis_c = 1'b0;
    end else if (fl3_q.dx0) begin
      vis_c = fl3_q.vvis;
    end else if (fl3_q.dy0) begin
      vis_c = fl3_q.hvis;
    end else if (!fl3_q.dyneg) begin
      vis_c = (n_q < hdxs_c) && (w_q > 0);
    end else begin
      vis_c = (w_q < hdxs_c) && (n_q > 0);
    end
  end

  always_comb begin
    side_d.vis     = vis_c;
    side_d.zmax    = fl3_q.zm;
    side_d.early   = fl3_q.early;
    side_d.ecx     = fl3_q.ecx;
    side_d.ecy     = fl3_q.ecy;
    side_d.fx_ge_w = fl3_q.fx_ge_w;
    side_d.fx_lt0  = fl3_q.fx_lt0;
    side_d.fy_ge_h = fl3_q.fy_ge_h;
    side_d.fy_lt0  = fl3_q.fy_lt0;
    side_d.mneg    = mneg_c;
    side_d.m       = m_q;
    side_d.dx      = fl3_q.dx;
    side_d.dyneg   = fl3_q.dyneg;
    side_d.ady     = fl3_q.ady;
    side_d.hdx     = fl3_q.hdx;
    side_d.wady    = fl3_q.wady;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q  <= st1_d;
    fl2_q  <= fl2_d;
    p1_q   <= p1_c;
    p2_q   <= p2_c;
    p3_q   <= p3_c;
    p4_q   <= p4_c;
    p5_q   <= p5_c;
    pp2_q  <= pp_c;
    m_q    <= diff_c[56:8];
    n_q    <= p3_q - p4_q;
    w_q    <= p5_q + p3_q - p4_q;
    pp3_q  <= pp2_q;
    fl3_q  <= fl2_q;
    side_o <= side_d;
    diva_o <= mneg_c ? DVW'(~m_q) : DVW'(m_q);
    divb_o <= pneg_c ? DVW'(~pp3_q) : DVW'(pp3_q);
    pneg_o <= pneg_c;
  end

endmodule

### design/scp_mid.sv
`timescale 1ns / 1ps
// Two stages after the intercept dividers: edge hits and the crossing dividend.
// Depends on scp_pkg.
module scp_mid #(
  parameter int unsigned SCREEN_WIDTH  = scp_pkg::DEF_W,
  parameter int unsigned SCREEN_HEIGHT = scp_pkg::DEF_H
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  scp_pkg::scp_side_t      side_i,
  input  logic [scp_pkg::DVW-1:0] quoa_i,
  input  logic [scp_pkg::DXW-1:0] rema_i,
  input  logic [scp_pkg::DVW-1:0] quob_i,
  input  logic                    pneg_i,
  output logic                    valid_o,
  output logic [scp_pkg::LW-1:0]  num_o,
  output logic [scp_pkg::DXW-1:0] den_o,
  output scp_pkg::scp_tail_t      tail_o
);
  import scp_pkg::*;

  localparam logic signed [PRW-1:0] HP   = PRW'(SCREEN_HEIGHT);
  localparam logic [XW-1:0]         WTOP = XW'(SCREEN_WIDTH - 1);
  localparam logic [XW-1:0]         HTOP = XW'(SCREEN_HEIGHT - 1);

  typedef struct packed {
    scp_side_t             s;
    logic signed [PRW-1:0] wi;
    logic signed [PRW-1:0] a0;
    logic                  yi_in;
    logic [XW-1:0]         yi_lo;
  } s5_t;

  // Stage 5: signed quotients, remainder and the crossing numerator.
  // Floor division of a negative value divides its complement and
  // complements the quotient.
  logic signed [MW-1:0] q1_c, q2_c;
  logic [DXW-1:0]       r1_c;
  s5_t                  s5_d, s5_q;
  logic                 v5_q;

  assign q1_c = side_i.mneg ? ~$signed({1'b0, quoa_i}) : $signed({1'b0, quoa_i});
  assign q2_c = pneg_i ? ~$signed({1'b0, quob_i}) : $signed({1'b0, quob_i});
  assign r1_c = side_i.mneg ? (side_i.dx - DXW'(1) - rema_i) : rema_i;

  always_comb begin
    s5_d.s     = side_i;
    s5_d.wi    = PRW'(q1_c) + PRW'(q2_c);
    s5_d.yi_in = !side_i.m[MW-1] && (PRW'(side_i.m) < $signed(PRW'(side_i.hdx)));
    s5_d.yi_lo = q1_c[XW-1:0];
    // (K - yi) * dx rewritten as K*dx - m + r so that no wide product is needed.
    s5_d.a0    = $signed(PRW'(side_i.fy_ge_h ? side_i.hdx : '0)) - PRW'(side_i.m)
                 + $signed(PRW'(r1_c));
  end

  // Stage 6: edge hits, clip choice, dividend for the crossing column.
  logic                  wi_in_c, hit_c, lo_c, hi_c;
  logic signed [PRW-1:0] a_c;
  scp_tail_t             tail_d;

  assign wi_in_c = !s5_q.wi[PRW-1] && (s5_q.wi < HP);
  assign hit_c   = (s5_q.s.fx_ge_w && wi_in_c) || (s5_q.s.fx_lt0 && s5_q.yi_in);
  assign a_c     = s5_q.s.dyneg ? -s5_q.a0 : s5_q.a0;
  assign lo_c    = a_c[PRW-1];
  assign hi_c    = !lo_c && (a_c >= $signed(PRW'(s5_q.s.wady)));

  always_comb begin
    tail_d.vis    = s5_q.s.vis;
    tail_d.zmax   = s5_q.s.zmax;
    tail_d.lo     = lo_c;
    tail_d.hi     = hi_c;
    tail_d.usediv = 1'b0;
    tail_d.fcx    = '0;
    tail_d.fcy    = '0;
    priority if (s5_q.s.early) begin
      tail_d.fcx = s5_q.s.ecx;
      tail_d.fcy = s5_q.s.ecy;
    end else if (hit_c) begin
      tail_d.fcx = s5_q.s.fx_ge_w ? WTOP : '0;
      tail_d.fcy = s5_q.s.fx_ge_w ? s5_q.wi[XW-1:0] : s5_q.yi_lo;
    end else if (s5_q.s.fy_ge_h) begin
      tail_d.usediv = 1'b1;
      tail_d.fcy    = HTOP;
    end else if (s5_q.s.fy_lt0) begin
      tail_d.usediv = 1'b1;
    end else begin
      tail_d.fcx = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v5_q    <= valid_i;
      valid_o <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q   <= s5_d;
    num_o  <= (lo_c || hi_c) ? '0 : LW'(a_c);
    den_o  <= s5_q.s.ady;
    tail_o <= tail_d;
  end

endmodule

### design/segment_screen_clip_unit.sv
`timescale 1ns / 1ps
// Top level of the segment screen clip unit: front stages, three dividers,
// middle stages and the result register. Depends on scp_pkg, scp_front,
// scp_div and scp_mid.
//
//  channel   handshake            payload    direction
//  -------   ------------------   --------   ---------
//  item      start / busy         item_i     in
//  result    done_o (strobe)      result_o   out
//
// An item is taken at every clock edge where start is high; busy is always
// low because the pipeline never stops. The result of an item passes through
// 4 + 48 + 2 + 37 + 1 = 92 register stages and is then shown on result_o with
// done_o high for one cycle. The depth is set by the two 48-step intercept
// dividers and the 37-step crossing-column divider, one quotient bit per stage.
// Reset clears only the valid bits that travel with each item, so no result
// is shown until an item has run through. There is no back pressure: the
// receiver takes every result in the cycle it is shown.
module segment_screen_clip_unit #(
  parameter int unsigned SCREEN_WIDTH  = scp_pkg::DEF_W,
  parameter int unsigned SCREEN_HEIGHT = scp_pkg::DEF_H
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  scp_pkg::scp_in_t  item_i,
  output logic              done_o,
  output scp_pkg::scp_out_t result_o
);
  import scp_pkg::*;

  localparam logic [XW-1:0] WTOP = XW'(SCREEN_WIDTH - 1);

  // The pipeline accepts an item in every cycle.
  assign busy = 1'b0;

  // Front stages: integer parts, products, visibility, early clips.
  logic              f_valid;
  scp_side_t         f_side;
  logic [DVW-1:0]    f_diva, f_divb;
  logic              f_pneg;

  scp_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start),
    .item_i (item_i),
    .valid_o(f_valid),
    .side_o (f_side),
    .diva_o (f_diva),
    .divb_o (f_divb),
    .pneg_o (f_pneg)
  );

  // Intercept divider: floor(m / dx) with remainder; it carries the side data.
  logic              a_valid;
  logic [DVW-1:0]    a_quo;
  logic [DXW-1:0]    a_rem;
  scp_side_t         a_side;

  scp_div #(
    .NW(DVW),
    .DW(DXW),
    .PW($bits(scp_side_t))
  ) u_div_yi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(f_valid),
    .num_i  (f_diva),
    .den_i  (f_side.dx),
    .side_i (f_side),
    .valid_o(a_valid),
    .quo_o  (a_quo),
    .rem_o  (a_rem),
    .side_o (a_side)
  );

  // Right-edge term floor(dy * W / dx); runs in lock step with the first one.
  logic [DVW-1:0]    b_quo;
  logic              b_pneg;

  scp_div #(
    .NW(DVW),
    .DW(DXW),
    .PW(1)
  ) u_div_wi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(f_valid),
    .num_i  (f_divb),
    .den_i  (f_side.dx),
    .side_i (f_pneg),
    .valid_o(),
    .quo_o  (b_quo),
    .rem_o  (),
    .side_o (b_pneg)
  );

  // Edge hits and the numerator of the crossing column.
  logic              m_valid;
  logic [LW-1:0]     m_num;
  logic [DXW-1:0]    m_den;
  scp_tail_t         m_tail;

  scp_mid #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(a_valid),
    .side_i (a_side),
    .quoa_i (a_quo),
    .rema_i (a_rem),
    .quob_i (b_quo),
    .pneg_i (b_pneg),
    .valid_o(m_valid),
    .num_o  (m_num),
    .den_o  (m_den),
    .tail_o (m_tail)
  );

  // Crossing column on the top or bottom edge. The dividend is only used
  // when the quotient is known to fall on screen.
  logic              c_valid;
  logic [LW-1:0]     c_quo;
  scp_tail_t         c_tail;

  scp_div #(
    .NW(LW),
    .DW(DXW),
    .PW($bits(scp_tail_t))
  ) u_div_cx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(m_valid),
    .num_i  (m_num),
    .den_i  (m_den),
    .side_i (m_tail),
    .valid_o(c_valid),
    .quo_o  (c_quo),
    .rem_o  (),
    .side_o (c_tail)
  );

  // Result register. A negative crossing saturates to column zero and one at
  // or beyond the width saturates to the last column.
  scp_out_t res_d;

  always_comb begin
    res_d.visible   = c_tail.vis;
    res_d.clip_y    = c_tail.fcy;
    res_d.depth_max = c_tail.zmax;
    if (!c_tail.usediv) begin
      res_d.clip_x = c_tail.fcx;
    end else if (c_tail.lo) begin
      res_d.clip_x = '0;
    end else if (c_tail.hi) begin
      res_d.clip_x = WTOP;
    end else begin
      res_d.clip_x = c_quo[XW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

endmodule

### verif/scp_checker.sv
`timescale 1ns / 1ps
// Checker for the segment screen clip unit: predicts every accepted item and
// compares each result strobe with the oldest prediction. Depends on scp_pkg.
module scp_checker #(
  parameter int unsigned SCREEN_WIDTH  = scp_pkg::DEF_W,
  parameter int unsigned SCREEN_HEIGHT = scp_pkg::DEF_H
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  scp_pkg::scp_in_t  item_i,
  input  logic              done_i,
  input  scp_pkg::scp_out_t result_i,
  output int                errors_o,
  output int                pending_o
);
  import scp_pkg::*;

  scp_out_t clip_queue[$];
  int       err_cnt = 0;
  int       pend_cnt = 0;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    longint r;
    if (b < 0) begin
      a = -a;
      b = -b;
    end
    q = a / b;
    r = a % b;
    if (r != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_pix(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic scp_out_t clip_segment(scp_in_t it);
    longint w, h, sx, sy, sz, ex, ey, ez;
    longint fx0, fy0, fx1, fy1, dx, dy, n, wsum, yi, wi, yc, cx, cy, zm;
    bit in0, in1, vis;
    scp_out_t res;
    w = SCREEN_WIDTH;
    h = SCREEN_HEIGHT;
    sx = it.start_x; sy = it.start_y; sz = it.start_z;
    ex = it.end_x;   ey = it.end_y;   ez = it.end_z;
    fx0 = sx >>> 8; fy0 = sy >>> 8;
    fx1 = ex >>> 8; fy1 = ey >>> 8;
    in0 = fx0 >= 0 && fx0 < w && fy0 >= 0 && fy0 < h;
    in1 = fx1 >= 0 && fx1 < w && fy1 >= 0 && fy1 < h;
    dx = fx1 - fx0;
    dy = fy1 - fy0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
    end
    if (in0 || in1) begin
      vis = 1;
    end else if ((fx0 < 0 && fx1 < 0) || (fx0 >= w && fx1 >= w) ||
                 (fy0 < 0 && fy1 < 0) || (fy0 >= h && fy1 >= h)) begin
      vis = 0;
    end else if (dx == 0) begin
      vis = fx0 >= 0 && fx0 < w;
    end else if (dy == 0) begin
      vis = fy0 >= 0 && fy0 < h;
    end else begin
      n = fy0 * dx - dy * fx0;
      wsum = dy * (w - 1) + n;
      if (dy >= 0) vis = n < h * dx && wsum > 0;
      else vis = wsum < h * dx && n > 0;
    end
    if (in0) begin
      cx = fx0; cy = fy0;
    end else if (dx == 0) begin
      cx = fx0; cy = (fy0 >= h) ? h - 1 : 0;
    end else if (dy == 0) begin
      cx = (fx0 >= w) ? w - 1 : 0; cy = fy0;
    end else begin
      yi = floor_div(sy * dx - dy * sx, 256 * dx);
      wi = floor_div(dy * w, dx) + yi;
      if ((fx0 >= w && wi >= 0 && wi < h) || (fx0 < 0 && yi >= 0 && yi < h)) begin
        cx = (fx0 >= w) ? w - 1 : 0;
        cy = (fx0 >= w) ? wi : yi;
      end else begin
        // Far-off intercepts are pinned so the crossing column saturates.
        yc = yi;
        if (yc > (64'sd1 <<< 37)) yc = 64'sd1 <<< 37;
        if (yc < -(64'sd1 <<< 37)) yc = -(64'sd1 <<< 37);
        if (fy0 >= h) begin
          cx = floor_div((h - yc) * dx, dy); cy = h - 1;
        end else if (fy0 < 0) begin
          cx = floor_div(-yc * dx, dy); cy = 0;
        end else begin
          cx = 0; cy = 0;
        end
      end
    end
    zm = (sz >= ez) ? sz : ez;
    zm = zm / 256;
    res.visible   = vis;
    res.clip_x    = XW'(clamp_pix(cx, w - 1));
    res.clip_y    = XW'(clamp_pix(cy, h - 1));
    res.depth_max = CW'(zm);
    return res;
  endfunction

  assign errors_o  = err_cnt;
  assign pending_o = pend_cnt;

  always @(posedge clk_i) begin
    scp_out_t want;
    if (rst_ni && start_i && !busy_i) clip_queue.push_back(clip_segment(item_i));
    if (rst_ni && done_i) begin
      if (clip_queue.size() == 0) begin
        $error("result with no item waiting");
        err_cnt++;
      end else begin
        want = clip_queue.pop_front();
        if (want.visible !== result_i.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, result_i.visible);
          err_cnt++;
        end
        if (want.clip_x !== result_i.clip_x) begin
          $error("clip_x: expected %0d, got %0d", want.clip_x, result_i.clip_x);
          err_cnt++;
        end
        if (want.clip_y !== result_i.clip_y) begin
          $error("clip_y: expected %0d, got %0d", want.clip_y, result_i.clip_y);
          err_cnt++;
        end
        if (want.depth_max !== result_i.depth_max) begin
          $error("depth_max: expected %0d, got %0d", want.depth_max, result_i.depth_max);
          err_cnt++;
        end
      end
    end
    pend_cnt = clip_queue.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Top of the segment screen clip testbench: clock, reset, segment stimulus and
// the verdict. Depends on scp_pkg, scp_checker and segment_screen_clip_unit.
module testbench;
  import scp_pkg::*;

  // The drain wait after the last result leaves margin beyond the pipeline depth.
  localparam int DRAIN_CYCLES = 200;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  scp_in_t  item_i = '0;
  logic     done_o;
  scp_out_t result_o;
  int       errors;
  int       pending;
  int       idle_pct;

  always #1 clk_i = ~clk_i;

  segment_screen_clip_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  scp_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_i   (busy),
    .item_i   (item_i),
    .done_i   (done_o),
    .result_i (result_o),
    .errors_o (errors),
    .pending_o(pending)
  );

  // Sends one segment. Before it the sender may sit idle for some cycles,
  // with start low; start is only lowered when a gap really happens, so a
  // back-to-back item never sees start dip within one time step.
  task automatic send_segment(input scp_in_t seg);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= seg;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_coords(input int sx, input int sy, input int ex, input int ey,
                             input int sz, input int ez);
    scp_in_t seg;
    seg.start_x = sx; seg.start_y = sy; seg.start_z = sz;
    seg.end_x   = ex; seg.end_y   = ey; seg.end_z   = ez;
    send_segment(seg);
  endtask

  // A Q24.8 coordinate: mostly around the screen so that clipping and the
  // slope tests are exercised, sometimes anywhere in the 32-bit range.
  function automatic int rand_coord();
    int pix;
    if ($urandom_range(9) == 0) return int'($urandom());
    pix = int'($urandom_range(5119)) - 2048;
    return pix * 256 + int'($urandom_range(255));
  endfunction

  function automatic scp_in_t rand_segment();
    scp_in_t seg;
    seg.start_x = rand_coord();
    seg.start_y = rand_coord();
    seg.end_x   = rand_coord();
    seg.end_y   = rand_coord();
    seg.start_z = $urandom();
    seg.end_z   = $urandom();
    // Vertical and horizontal segments need matching integer parts.
    case ($urandom_range(7))
      0: seg.end_x = {seg.start_x[31:8], 8'($urandom())};
      1: seg.end_y = {seg.start_y[31:8], 8'($urandom())};
      default: ;
    endcase
    return seg;
  endfunction

  initial begin
    #200000;
    $display("[segment_screen_clip_unit] ERROR");
    $finish;
  end

  initial begin
    int waited;
    idle_pct = 12;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed segments: on-screen endpoints, trivial rejects on each edge,
    // vertical and horizontal cases, sloped crossings and extreme values.
    send_coords(100 * 256, 200 * 256, 300 * 256, 400 * 256, 5 * 256, -7 * 256);
    send_coords(-50 * 256, 500 * 256, 500 * 256, 500 * 256 + 3, 0, 0);
    send_coords(-10 * 256, 10 * 256, -20 * 256, 900 * 256, -1, -255);
    send_coords(1100 * 256, 10 * 256, 1500 * 256, 900 * 256, 256, 255);
    send_coords(10 * 256, -5 * 256, 900 * 256, -9 * 256, 0, 0);
    send_coords(10 * 256, 1030 * 256, 900 * 256, 2000 * 256, 0, 0);
    send_coords(500 * 256, -100 * 256, 500 * 256 + 77, 2000 * 256, 0, 0);
    send_coords(500 * 256, 2000 * 256, 500 * 256, -100 * 256, 0, 0);
    send_coords(-100 * 256, 600 * 256, 1500 * 256, 600 * 256, 0, 0);
    send_coords(1500 * 256, 600 * 256, -100 * 256, 600 * 256, 0, 0);
    send_coords(-100 * 256, -100 * 256, 1500 * 256, 1500 * 256, 0, 0);
    send_coords(1500 * 256, 100 * 256, 100 * 256, 1500 * 256, 0, 0);
    send_coords(-200 * 256, 1500 * 256, 1500 * 256, -300 * 256, 0, 0);
    send_coords(-300 * 256, 2000 * 256, 200 * 256, -2000 * 256 + 9, 0, 0);
    send_coords(-2000 * 256, 100 * 256, 2000 * 256, 1200 * 256, 0, 0);
    send_coords(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh80000000);
    send_coords(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000);
    send_coords(32'sh80000000, 500 * 256, 32'sh7fffffff, 501 * 256, 0, 32'sh7fffffff);
    send_coords(1023 * 256 + 255, 1023 * 256 + 255, 1024 * 256, 1024 * 256, 0, 0);
    send_coords(-1, -1, 0, 0, 0, 0);

    // Random segments in three phases of sender idling.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 87 : 0;
      repeat (410) send_segment(rand_segment());
    end
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[segment_screen_clip_unit] OK");
    end else begin
      $display("[segment_screen_clip_unit] ERROR");
    end
    $finish;
  end

endmodule
